### rtl/pit3_pkg.sv
package pit3_pkg;

   localparam int COORD_BITS    = 16;
   localparam int VERTEX_BITS   = 3 * COORD_BITS;
   localparam int DIFF_BITS     = COORD_BITS + 1;
   localparam int PROD_BITS     = 2 * DIFF_BITS;
   localparam int CROSS_BITS    = PROD_BITS + 1;
   localparam int DOT_BITS      = 2 * CROSS_BITS;
   localparam int SUM_BITS      = DOT_BITS + 2;
   localparam int CSR_ADDR_BITS = 2;
   localparam int PIPE_STAGES   = 5;

   typedef enum logic [CSR_ADDR_BITS-1:0] {
      REG_VERTEX_A = 2'd0,
      REG_VERTEX_B = 2'd1,
      REG_VERTEX_C = 2'd2
   } pit3_csr_type;

   // packing matches the vertex registers: z high, x low
   typedef struct packed {
      logic signed [COORD_BITS-1:0] z;
      logic signed [COORD_BITS-1:0] y;
      logic signed [COORD_BITS-1:0] x;
   } pit3_vec_type;

   typedef struct packed {
      logic signed [DIFF_BITS-1:0] z;
      logic signed [DIFF_BITS-1:0] y;
      logic signed [DIFF_BITS-1:0] x;
   } pit3_diff_type;

   typedef struct packed {
      logic signed [CROSS_BITS-1:0] z;
      logic signed [CROSS_BITS-1:0] y;
      logic signed [CROSS_BITS-1:0] x;
   } pit3_cross_type;

   typedef struct packed {
      logic signed [COORD_BITS-1:0] point_x;
      logic signed [COORD_BITS-1:0] point_y;
      logic signed [COORD_BITS-1:0] point_z;
   } pit3_req_type;

   typedef struct packed {
      logic inside_res;
      logic degenerate;
   } pit3_rsp_type;

   typedef struct packed {
      logic s1_load;
      logic s2_load;
      logic s3_load;
      logic s4_load;
      logic s5_load;
   } pit3_adv_type;

   function automatic logic signed [DIFF_BITS-1:0] sub_coord(
      input logic signed [COORD_BITS-1:0] a,
      input logic signed [COORD_BITS-1:0] b
   );
      return DIFF_BITS'(a) - DIFF_BITS'(b);
   endfunction

   function automatic pit3_diff_type sub_vec(input pit3_vec_type a, input pit3_vec_type b);
      pit3_diff_type r;
      r.x = sub_coord(a.x, b.x);
      r.y = sub_coord(a.y, b.y);
      r.z = sub_coord(a.z, b.z);
      return r;
   endfunction

   function automatic logic signed [PROD_BITS-1:0] mul_diff(
      input logic signed [DIFF_BITS-1:0] a,
      input logic signed [DIFF_BITS-1:0] b
   );
      return PROD_BITS'(a) * PROD_BITS'(b);
   endfunction

   function automatic logic signed [CROSS_BITS-1:0] sub_prod(
      input logic signed [PROD_BITS-1:0] a,
      input logic signed [PROD_BITS-1:0] b
   );
      return CROSS_BITS'(a) - CROSS_BITS'(b);
   endfunction

   function automatic logic signed [DOT_BITS-1:0] mul_cross(
      input logic signed [CROSS_BITS-1:0] a,
      input logic signed [CROSS_BITS-1:0] b
   );
      return DOT_BITS'(a) * DOT_BITS'(b);
   endfunction

endpackage

### rtl/point_in_triangle_3d.sv
// Same-side point-in-triangle test for a triangle in 3-D, signed Q8.8.
// Configuration: write vertex_a, vertex_b, vertex_c (index 0, 1, 2) through
// csr_we/csr_addr/csr_wdata, packed z[47:32] y[31:16] x[15:0]; a write takes
// effect at the clock edge, writes to other indexes are dropped. Write only
// while no item is in flight.
// Input channel req_*: one query point per item, valid/ready handshake.
// Output channel rsp_*: one result per item, in order: inside_res is set
// when the point lies on the inner side of every edge (edges count as
// inside), degenerate when two vertices are equal.
// Pipeline: rsp_valid rises once the item has passed five register stages
// (differences, cross terms, cross products, dot terms, sum and result), the
// first of them loaded at the accepting edge.
// Throughput: one item per cycle while the receiver does not stall.
// Reset clears the pipeline valid bits and all three vertices to zero.
// When the receiver stalls, each stage holds its item; empty stages still
// fill, so req_ready drops only once the whole pipeline is full.
module point_in_triangle_3d
   import pit3_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_ready,
   input  pit3_req_type             req_data,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output pit3_rsp_type             rsp_data,
   input  logic                     csr_we,
   input  logic [CSR_ADDR_BITS-1:0] csr_addr,
   input  logic [VERTEX_BITS-1:0]   csr_wdata
);

   logic [VERTEX_BITS-1:0] vertex_a_ff, vertex_b_ff, vertex_c_ff;
   logic [VERTEX_BITS-1:0] vertex_a_in, vertex_b_in, vertex_c_in;
   pit3_vec_type           va, vb, vc, point;
   pit3_adv_type           adv;
   logic [2:0]             nonneg;
   logic                   degen_in;
   logic                   deg1_ff, deg2_ff, deg3_ff, deg4_ff;
   pit3_rsp_type           rsp_ff;

   // configuration registers
   always_comb begin
      vertex_a_in = vertex_a_ff;
      vertex_b_in = vertex_b_ff;
      vertex_c_in = vertex_c_ff;
      if (csr_we) begin
         case (pit3_csr_type'(csr_addr))
            REG_VERTEX_A: vertex_a_in = csr_wdata;
            REG_VERTEX_B: vertex_b_in = csr_wdata;
            REG_VERTEX_C: vertex_c_in = csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vertex_a_ff <= '0;
         vertex_b_ff <= '0;
         vertex_c_ff <= '0;
      end else begin
         vertex_a_ff <= vertex_a_in;
         vertex_b_ff <= vertex_b_in;
         vertex_c_ff <= vertex_c_in;
      end
   end

   assign va = pit3_vec_type'(vertex_a_ff);
   assign vb = pit3_vec_type'(vertex_b_ff);
   assign vc = pit3_vec_type'(vertex_c_ff);

   assign point.x = req_data.point_x;
   assign point.y = req_data.point_y;
   assign point.z = req_data.point_z;

   assign degen_in = (vertex_a_ff == vertex_b_ff) || (vertex_a_ff == vertex_c_ff) ||
                     (vertex_b_ff == vertex_c_ff);

   pit3_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .adv       (adv)
   );

   // edge b to c, opposite a
   pit3_edge u_edge_bc (
      .clock      (clock),
      .adv        (adv),
      .point      (point),
      .edge_start (vb),
      .edge_end   (vc),
      .opposite   (va),
      .nonneg     (nonneg[0])
   );

   // edge c to a, opposite b
   pit3_edge u_edge_ca (
      .clock      (clock),
      .adv        (adv),
      .point      (point),
      .edge_start (vc),
      .edge_end   (va),
      .opposite   (vb),
      .nonneg     (nonneg[1])
   );

   // edge a to b, opposite c
   pit3_edge u_edge_ab (
      .clock      (clock),
      .adv        (adv),
      .point      (point),
      .edge_start (va),
      .edge_end   (vb),
      .opposite   (vc),
      .nonneg     (nonneg[2])
   );

   // degenerate flag follows its item down the pipeline
   always_ff @(posedge clock) begin
      if (adv.s1_load) begin
         deg1_ff <= degen_in;
      end
      if (adv.s2_load) begin
         deg2_ff <= deg1_ff;
      end
      if (adv.s3_load) begin
         deg3_ff <= deg2_ff;
      end
      if (adv.s4_load) begin
         deg4_ff <= deg3_ff;
      end
      if (adv.s5_load) begin
         rsp_ff.inside_res <= &nonneg;
         rsp_ff.degenerate <= deg4_ff;
      end
   end

   assign rsp_data = rsp_ff;

endmodule

### rtl/pit3_ctrl.sv
module pit3_ctrl
   import pit3_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_ready,
   output logic         rsp_valid,
   input  logic         rsp_ready,
   output pit3_adv_type adv
);

   logic [PIPE_STAGES-1:0] valid_ff;
   logic [PIPE_STAGES-1:0] valid_in;
   logic [PIPE_STAGES:0]   ready;

   // a stage takes a new item when it is empty or its item moves on
   always_comb begin
      ready[PIPE_STAGES] = rsp_ready;
      for (int i = PIPE_STAGES - 1; i >= 0; i--) begin
         ready[i] = !valid_ff[i] || ready[i+1];
      end
      valid_in[0] = ready[0] ? req_valid : valid_ff[0];
      for (int i = 1; i < PIPE_STAGES; i++) begin
         valid_in[i] = ready[i] ? valid_ff[i-1] : valid_ff[i];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   assign req_ready   = ready[0];
   assign rsp_valid   = valid_ff[PIPE_STAGES-1];
   assign adv.s1_load = ready[0];
   assign adv.s2_load = ready[1];
   assign adv.s3_load = ready[2];
   assign adv.s4_load = ready[3];
   assign adv.s5_load = ready[4];

endmodule

### rtl/pit3_edge.sv
module pit3_edge
   import pit3_pkg::*;
(
   input  logic         clock,
   input  pit3_adv_type adv,
   input  pit3_vec_type point,
   input  pit3_vec_type edge_start,
   input  pit3_vec_type edge_end,
   input  pit3_vec_type opposite,
   output logic         nonneg
);

   pit3_diff_type               u_ff, w_ff, v_ff;
   logic signed [PROD_BITS-1:0] pw_ff [6];
   logic signed [PROD_BITS-1:0] pv_ff [6];
   pit3_cross_type              n1_ff, n2_ff;
   logic signed [DOT_BITS-1:0]  dot_ff [3];
   logic signed [SUM_BITS-1:0]  dot_sum;

   // stage 1: edge and offsets from its start
   always_ff @(posedge clock) begin
      if (adv.s1_load) begin
         u_ff <= sub_vec(edge_end, edge_start);
         w_ff <= sub_vec(point, edge_start);
         v_ff <= sub_vec(opposite, edge_start);
      end
   end

   // stage 2: cross product terms
   always_ff @(posedge clock) begin
      if (adv.s2_load) begin
         pw_ff[0] <= mul_diff(u_ff.y, w_ff.z);
         pw_ff[1] <= mul_diff(u_ff.z, w_ff.y);
         pw_ff[2] <= mul_diff(u_ff.z, w_ff.x);
         pw_ff[3] <= mul_diff(u_ff.x, w_ff.z);
         pw_ff[4] <= mul_diff(u_ff.x, w_ff.y);
         pw_ff[5] <= mul_diff(u_ff.y, w_ff.x);
         pv_ff[0] <= mul_diff(u_ff.y, v_ff.z);
         pv_ff[1] <= mul_diff(u_ff.z, v_ff.y);
         pv_ff[2] <= mul_diff(u_ff.z, v_ff.x);
         pv_ff[3] <= mul_diff(u_ff.x, v_ff.z);
         pv_ff[4] <= mul_diff(u_ff.x, v_ff.y);
         pv_ff[5] <= mul_diff(u_ff.y, v_ff.x);
      end
   end

   // stage 3: cross products
   always_ff @(posedge clock) begin
      if (adv.s3_load) begin
         n1_ff.x <= sub_prod(pw_ff[0], pw_ff[1]);
         n1_ff.y <= sub_prod(pw_ff[2], pw_ff[3]);
         n1_ff.z <= sub_prod(pw_ff[4], pw_ff[5]);
         n2_ff.x <= sub_prod(pv_ff[0], pv_ff[1]);
         n2_ff.y <= sub_prod(pv_ff[2], pv_ff[3]);
         n2_ff.z <= sub_prod(pv_ff[4], pv_ff[5]);
      end
   end

   // stage 4: dot product terms
   always_ff @(posedge clock) begin
      if (adv.s4_load) begin
         dot_ff[0] <= mul_cross(n1_ff.x, n2_ff.x);
         dot_ff[1] <= mul_cross(n1_ff.y, n2_ff.y);
         dot_ff[2] <= mul_cross(n1_ff.z, n2_ff.z);
      end
   end

   always_comb begin
      dot_sum = SUM_BITS'(dot_ff[0]) + SUM_BITS'(dot_ff[1]) + SUM_BITS'(dot_ff[2]);
      nonneg  = !dot_sum[SUM_BITS-1];
   end

endmodule
